[hw/rtl/pwtg_pkg.sv]
// Shared types and codes for the periodic waveform table generator.
package pwtg_pkg;

	// wave_kind register codes
	localparam logic [1:0] WK_SINE   = 2'd0;
	localparam logic [1:0] WK_SAW    = 2'd1;
	localparam logic [1:0] WK_TRI    = 2'd2;
	localparam logic [1:0] WK_SQUARE = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_WAVE_KIND = 2'd0;
	localparam logic [1:0] CFG_RATE_CODE = 2'd1;
	localparam logic [1:0] CFG_TONE_FREQ = 2'd2;

	// rate_code values
	localparam logic [3:0] RC_6258  = 4'd0;
	localparam logic [3:0] RC_12517 = 4'd1;
	localparam logic [3:0] RC_25033 = 4'd2;
	localparam logic [3:0] RC_50066 = 4'd3;

	// divider load sources
	typedef logic [1:0] div_sel_t;
	localparam div_sel_t DL_RATE  = 2'd0;
	localparam div_sel_t DL_PHASE = 2'd1;
	localparam div_sel_t DL_RAMP  = 2'd2;

	// sine polynomial micro-steps, run in order from SS_X to SS_S
	typedef logic [3:0] sstep_t;
	localparam sstep_t SS_X   = 4'd0;
	localparam sstep_t SS_X2  = 4'd1;
	localparam sstep_t SS_R42 = 4'd2;
	localparam sstep_t SS_C42 = 4'd3;
	localparam sstep_t SS_Y1  = 4'd4;
	localparam sstep_t SS_R20 = 4'd5;
	localparam sstep_t SS_C20 = 4'd6;
	localparam sstep_t SS_Y2  = 4'd7;
	localparam sstep_t SS_R6  = 4'd8;
	localparam sstep_t SS_C6  = 4'd9;
	localparam sstep_t SS_S   = 4'd10;

	typedef struct packed {
		logic     accept;
		logic     div_load;
		div_sel_t div_sel;
		logic     div_step;
		logic     per_load;
		logic     kind_load;
		logic     ramp_num;
		logic     ramp_val;
		logic     mul;
		logic     wb;
		sstep_t   sstep;
		logic     sin_val;
		logic     fin;
	} cmd_t;

	typedef struct packed {
		logic       tf_zero;
		logic       p_zero;
		logic [1:0] kind;
	} stat_t;

endpackage

[hw/rtl/pwtg_ctrl.sv]
// Sequencer for the waveform generator: steps the datapath through one sample.
module pwtg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  pwtg_pkg::stat_t stat,
	output pwtg_pkg::cmd_t  cmd
);
	import pwtg_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DIV   = 4'd1;
	localparam logic [3:0] ST_PER   = 4'd2;
	localparam logic [3:0] ST_KIND  = 4'd3;
	localparam logic [3:0] ST_RAMP0 = 4'd4;
	localparam logic [3:0] ST_RAMP1 = 4'd5;
	localparam logic [3:0] ST_RAMPV = 4'd6;
	localparam logic [3:0] ST_SMUL  = 4'd7;
	localparam logic [3:0] ST_SWB   = 4'd8;
	localparam logic [3:0] ST_SINV  = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	// last count of a 16-step and an 8-step division
	localparam logic [3:0] LAST16 = 4'd15;
	localparam logic [3:0] LAST8  = 4'd7;

	logic [3:0] state_q, next_state, ret_q;
	logic [3:0] cnt_q;
	sstep_t     sstep_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.sstep  = sstep_q;
		next_state = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept   = 1'b1;
					cmd.div_load = 1'b1;
					cmd.div_sel  = DL_RATE;
					next_state   = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0)
					next_state = ret_q;
			end
			ST_PER: begin
				cmd.per_load = 1'b1;
				next_state   = ST_KIND;
			end
			ST_KIND: begin
				if (stat.tf_zero || stat.p_zero) begin
					next_state = ST_IDLE;
				end else begin
					cmd.kind_load = 1'b1;
					case (stat.kind)
						WK_SINE: begin
							cmd.div_load = 1'b1;
							cmd.div_sel  = DL_PHASE;
							next_state   = ST_DIV;
						end
						WK_SAW, WK_TRI: next_state = ST_RAMP0;
						default:        next_state = ST_FIN;
					endcase
				end
			end
			ST_RAMP0: begin
				cmd.ramp_num = 1'b1;
				next_state   = ST_RAMP1;
			end
			ST_RAMP1: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = DL_RAMP;
				next_state   = ST_DIV;
			end
			ST_RAMPV: begin
				cmd.ramp_val = 1'b1;
				next_state   = ST_FIN;
			end
			ST_SMUL: begin
				cmd.mul    = 1'b1;
				next_state = ST_SWB;
			end
			ST_SWB: begin
				cmd.wb     = 1'b1;
				next_state = (sstep_q == SS_S) ? ST_SINV : ST_SMUL;
			end
			ST_SINV: begin
				cmd.sin_val = 1'b1;
				next_state  = ST_FIN;
			end
			ST_FIN: begin
				// wait here only while the previous beat is still unclaimed
				if (!out_valid_q || out_ready) begin
					cmd.fin    = 1'b1;
					next_state = ST_IDLE;
				end
			end
			default: next_state = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			cnt_q       <= '0;
			sstep_q     <= SS_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (state_q == ST_IDLE && in_valid) begin
				cnt_q <= LAST16;
				ret_q <= ST_PER;
			end else if (state_q == ST_KIND && stat.kind == WK_SINE) begin
				cnt_q   <= LAST16;
				ret_q   <= ST_SMUL;
				sstep_q <= SS_X;
			end else if (state_q == ST_RAMP1) begin
				cnt_q <= LAST8;
				ret_q <= ST_RAMPV;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q - 4'd1;
			end else if (state_q == ST_SWB) begin
				sstep_q <= sstep_q + 4'd1;
			end
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while a sample was in progress");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_FIN))
		else $error("output valid raised outside the finish step");

	a_no_result_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KIND && (stat.tf_zero || stat.p_zero)) |=> (in_ready && !$rose(out_valid)))
		else $error("zero period produced a result");

endmodule

[hw/rtl/pwtg_dp.sv]
// Datapath: config registers, shared divider, multiplier, period and sample logic.
module pwtg_dp #(
	parameter int unsigned MAX_PERIOD = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pwtg_pkg::cmd_t       cmd,
	output pwtg_pkg::stat_t      stat,
	input  logic                 restart,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output logic signed [7:0]    sample,
	output logic [15:0]          sample_index,
	output logic [16:0]          period_length,
	output logic                 last
);
	import pwtg_pkg::*;

	localparam logic [16:0] PMax = 17'(MAX_PERIOD);
	localparam logic [15:0] HMax = 16'(MAX_PERIOD / 2);

	// quarter-wave step pi/2 / 16384 in Q30, and floor(2^32 / c) reciprocals
	localparam logic [31:0] HALF_PI_STEP = 32'd102944;
	localparam logic [31:0] R42 = 32'd102261126;
	localparam logic [31:0] R20 = 32'd214748364;
	localparam logic [31:0] R6  = 32'd715827882;
	localparam logic [5:0]  C42 = 6'd42;
	localparam logic [5:0]  C20 = 6'd20;
	localparam logic [5:0]  C6  = 6'd6;
	localparam logic [30:0] Q30   = 31'h4000_0000;
	localparam logic [37:0] Q30_M = 38'h00_4000_0000;

	localparam logic [7:0] SQ_HIGH = 8'h7F;
	localparam logic [7:0] SQ_LOW  = 8'h80;

	logic [1:0]  wave_kind_q;
	logic [3:0]  rate_code_q;
	logic [15:0] tone_freq_q;

	logic [15:0] pos_q, k_q, k_w;
	logic [16:0] p_q;
	logic [15:0] h_q;

	logic [16:0] rem_q, den_q;
	logic [15:0] low_q, quo_q;

	logic [16:0] num_q;
	logic        neg_q;
	logic [1:0]  quad_q;
	logic [31:0] x_q, x2_q, y_q, quos_q;
	logic [30:0] t_q;
	logic [37:0] m_q;
	logic [63:0] prod_q;
	logic [7:0]  val_q;

	logic [7:0]  sample_q;
	logic [15:0] index_q;
	logic [16:0] period_q;
	logic        last_q;

	logic [15:0] rate;
	logic [14:0] hd;
	logic [15:0] he, hs;
	logic [16:0] pe, ps;
	logic [17:0] r2, rdiff;
	logic        ge;
	logic [24:0] n_w, base_w, mag_w;
	logic        nlt;
	logic        tri_hi;
	logic [14:0] qsel;
	logic [31:0] mul_a, mul_b;
	logic [31:0] dvd, rem_c;
	logic [5:0]  cst;
	logic        corr;
	logic [30:0] t_next;
	logic [30:0] s_w;
	logic [37:0] m_next, m_dif, m_und;
	logic [38:0] m_sum;
	logic [7:0]  sin_v;
	logic        last_w;
	logic [15:0] k_inc;

	function automatic logic [15:0] rate_of(input logic [3:0] code);
		case (code)
			RC_6258:  return 16'd6258;
			RC_12517: return 16'd12517;
			RC_25033: return 16'd25033;
			RC_50066: return 16'd50066;
			default:  return 16'd0;
		endcase
	endfunction

	assign stat.tf_zero = (tone_freq_q == '0);
	assign stat.p_zero  = (p_q == '0);
	assign stat.kind    = wave_kind_q;

	assign sample        = signed'(sample_q);
	assign sample_index  = index_q;
	assign period_length = period_q;
	assign last          = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_kind_q <= WK_SINE;
			rate_code_q <= RC_50066;
			tone_freq_q <= 16'd440;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WAVE_KIND: wave_kind_q <= cfg_data[1:0];
				CFG_RATE_CODE: rate_code_q <= cfg_data[3:0];
				CFG_TONE_FREQ: tone_freq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		rate = rate_of(rate_code_q);
		// period from the quotient rate / frequency, rounded up to even
		hd = quo_q[15:1];
		he = {1'b0, hd} + 16'(hd[0]);
		hs = (he > HMax) ? HMax : he;
		pe = {1'b0, quo_q} + 17'(quo_q[0]);
		ps = (pe > PMax) ? PMax : pe;
		// a register write may leave the position past the period end
		k_w = ({1'b0, pos_q} >= p_q) ? '0 : pos_q;
		k_inc  = k_q + 16'd1;
		last_w = ({1'b0, k_q} + 17'd1) == p_q;
	end

	// restoring divider, one quotient bit per step
	always_comb begin
		r2    = {rem_q, low_q[15]};
		rdiff = r2 - {1'b0, den_q};
		ge    = (r2 >= {1'b0, den_q});
	end

	// ramp: |255*num - 128*den| and its sign
	always_comb begin
		tri_hi = (wave_kind_q == WK_TRI) && (k_q >= h_q);
		n_w    = {num_q, 8'h00} - {8'h00, num_q};
		base_w = {1'b0, den_q, 7'h00};
		nlt    = (n_w < base_w);
		mag_w  = nlt ? (base_w - n_w) : (n_w - base_w);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= '0;
			case (cmd.div_sel)
				DL_RATE: begin
					rem_q <= '0;
					low_q <= rate;
					den_q <= {1'b0, tone_freq_q};
				end
				DL_PHASE: begin
					rem_q <= {1'b0, k_w};
					low_q <= '0;
					den_q <= p_q;
				end
				default: begin
					// quotient fits 8 bits: top of the magnitude seeds the remainder
					rem_q <= {1'b0, mag_w[23:8]};
					low_q <= {mag_w[7:0], 8'h00};
					neg_q <= nlt;
				end
			endcase
		end else if (cmd.div_step) begin
			rem_q <= ge ? rdiff[16:0] : r2[16:0];
			low_q <= {low_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end else if (cmd.ramp_num) begin
			num_q <= tri_hi ? ({h_q, 1'b0} - {1'b0, k_q}) : {1'b0, k_q};
			den_q <= (wave_kind_q == WK_SAW) ? p_q : {1'b0, h_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.per_load) begin
			h_q <= hs;
			p_q <= (wave_kind_q == WK_SINE || wave_kind_q == WK_SAW) ? ps : {hs, 1'b0};
		end
		if (cmd.kind_load) begin
			k_q   <= k_w;
			val_q <= (k_w < h_q) ? SQ_HIGH : SQ_LOW;
		end else if (cmd.ramp_val) begin
			val_q <= neg_q ? (8'd0 - quo_q[7:0]) : quo_q[7:0];
		end else if (cmd.sin_val) begin
			val_q <= sin_v;
		end
	end

	// sine: quadrant fold, then one shared 32x32 multiplier per step
	always_comb begin
		qsel  = quo_q[14] ? (15'd16384 - {1'b0, quo_q[13:0]}) : {1'b0, quo_q[13:0]};
		mul_a = '0;
		mul_b = '0;
		case (cmd.sstep)
			SS_X: begin
				mul_a = {17'd0, qsel};
				mul_b = HALF_PI_STEP;
			end
			SS_X2: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			SS_R42: begin
				mul_a = x2_q;
				mul_b = R42;
			end
			SS_R20: begin
				mul_a = y_q;
				mul_b = R20;
			end
			SS_R6: begin
				mul_a = y_q;
				mul_b = R6;
			end
			SS_C42: begin
				mul_a = quos_q;
				mul_b = {26'd0, C42};
			end
			SS_C20: begin
				mul_a = quos_q;
				mul_b = {26'd0, C20};
			end
			SS_C6: begin
				mul_a = quos_q;
				mul_b = {26'd0, C6};
			end
			SS_Y1, SS_Y2: begin
				mul_a = x2_q;
				mul_b = {1'b0, t_q};
			end
			SS_S: begin
				mul_a = x_q;
				mul_b = {1'b0, t_q};
			end
			default: ;
		endcase
	end

	// reciprocal quotient is low by at most one; fix it from the remainder
	always_comb begin
		case (cmd.sstep)
			SS_C42: begin
				dvd = x2_q;
				cst = C42;
			end
			SS_C20: begin
				dvd = y_q;
				cst = C20;
			end
			default: begin
				dvd = y_q;
				cst = C6;
			end
		endcase
		rem_c  = dvd - prod_q[31:0];
		corr   = (rem_c >= {26'd0, cst});
		t_next = Q30 - quos_q[30:0] - {30'd0, corr};
		s_w    = prod_q[60:30];
		m_next = {s_w, 7'd0} - {7'd0, s_w};
		m_dif  = m_q - Q30_M;
		m_und  = Q30_M - m_q;
		m_sum  = {1'b0, m_q} + {1'b0, Q30_M};
		if (!quad_q[1])
			sin_v = (m_q >= Q30_M) ? m_dif[37:30] : (8'd0 - m_und[37:30]);
		else
			sin_v = 8'd0 - m_sum[37:30];
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= mul_a * mul_b;
			if (cmd.sstep == SS_X)
				quad_q <= quo_q[15:14];
		end
		if (cmd.wb) begin
			case (cmd.sstep)
				SS_X:                  x_q    <= prod_q[31:0];
				SS_X2:                 x2_q   <= prod_q[61:30];
				SS_R42, SS_R20, SS_R6: quos_q <= prod_q[63:32];
				SS_C42, SS_C20, SS_C6: t_q    <= t_next;
				SS_Y1, SS_Y2:          y_q    <= prod_q[61:30];
				SS_S:                  m_q    <= m_next;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.accept && restart) begin
			pos_q <= '0;
		end else if (cmd.fin) begin
			pos_q <= last_w ? '0 : k_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			sample_q <= val_q;
			index_q  <= k_q;
			period_q <= p_q;
			last_q   <= last_w;
		end
	end

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && den_q != '0) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	a_index_in_period: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> ({1'b0, sample_index} < period_length))
		else $error("sample index beyond period");

	a_period_even: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (!period_length[0] && period_length != '0 && period_length <= PMax))
		else $error("period length odd, zero or above limit");

	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (last == (pos_q == '0)))
		else $error("position wrap disagrees with last flag");

endmodule

[hw/rtl/periodic_waveform_table_generator.sv]
// Top level of the periodic waveform table generator.
//
//   channel  dir  handshake              beat contents
//   in       in   in_valid / in_ready    restart
//   out      out  out_valid / out_ready  sample, sample_index, period_length, last
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample at a time, from accept to ready again; a beat that gives no sample
// (zero period) returns to ready without the finish step.
// Every beat runs the 16-step rate / frequency division; the sine adds a 16-step
// phase division and eleven passes through the shared 32x32 multiplier.
// The output register holds a finished sample; a new beat is taken meanwhile,
// and only its last step waits for out_ready. cfg_ready is always high.
// Reset: wave_kind sine, rate_code 3, tone_frequency 440, position 0.
module periodic_waveform_table_generator #(
	parameter int unsigned MAX_PERIOD = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] sample,
	output logic [15:0]       sample_index,
	output logic [16:0]       period_length,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import pwtg_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	pwtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pwtg_dp #(
		.MAX_PERIOD (MAX_PERIOD)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.restart       (restart),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.sample        (sample),
		.sample_index  (sample_index),
		.period_length (period_length),
		.last          (last)
	);

endmodule

[verif/testbench.sv]
// Self-checking testbench for the periodic waveform table generator.
`timescale 1ns / 1ps

module testbench;
	import pwtg_pkg::*;

	localparam int unsigned MAX_PERIOD  = 65536;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 80;   // outlasts a sine tick
	localparam int unsigned ITEM_TARGET = 1400;
	localparam int unsigned LONG_HOLD   = 500;

	// index with no register behind it
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam logic [3:0] RC_BAD = 4'd15;

	localparam longint unsigned Q30_ONE      = 64'd1073741824;
	localparam longint unsigned HALF_PI_STEP = 64'd102944;

	typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_EVERY4} rx_mode_t;

	typedef struct packed {
		logic signed [7:0] sample;
		logic [15:0]       index;
		logic [16:0]       plen;
		logic              last;
	} wave_beat_t;

	class waveform_tracker;
		bit [1:0]   kind;
		bit [3:0]   rcode;
		bit [15:0]  tone;
		bit [15:0]  pos;
		wave_beat_t due_samples[$];
		int         errors;
		int         samples_matched;
		int         ticks_silent;

		function new();
			kind = WK_SINE;
			rcode = RC_50066;
			tone = 16'd440;
			pos = 16'd0;
		endfunction

		function int unsigned rate_of(bit [3:0] code);
			case (code)
				RC_6258:  return 6258;
				RC_12517: return 12517;
				RC_25033: return 25033;
				RC_50066: return 50066;
				default:  return 0;
			endcase
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_WAVE_KIND: kind = val[1:0];
				CFG_RATE_CODE: rcode = val[3:0];
				CFG_TONE_FREQ: tone = val;
				default: ;
			endcase
		endfunction

		// samples per period; half is the triangle/square half period
		function int unsigned span(output int unsigned half);
			int unsigned d, p;
			half = 0;
			if (tone == 0)
				return 0;
			d = rate_of(rcode) / tone;
			if (kind == WK_SINE || kind == WK_SAW) begin
				p = d;
				if (p[0])
					p++;
				if (p > MAX_PERIOD)
					p = MAX_PERIOD;
				return p;
			end
			half = d / 2;
			if (half[0])
				half++;
			if (half > MAX_PERIOD / 2)
				half = MAX_PERIOD / 2;
			return 2 * half;
		endfunction

		function int ramp_at(longint unsigned num, longint unsigned den);
			longint unsigned n, base;
			n = 255 * num;
			base = 128 * den;
			if (n >= base)
				return int'((n - base) / den);
			return -int'((base - n) / den);
		endfunction

		// 16-bit turn phase, quarter-wave odd polynomial in Q30
		function int sine_at(longint unsigned k, longint unsigned p);
			longint unsigned ph, quad, q, x, x2, t, s, m;
			ph = (k << 16) / p;
			quad = (ph >> 14) & 64'd3;
			q = ph & 64'h3FFF;
			if (quad[0])
				q = 64'd16384 - q;
			x = q * HALF_PI_STEP;
			x2 = (x * x) >> 30;
			t = Q30_ONE - x2 / 42;
			t = Q30_ONE - ((x2 * t) >> 30) / 20;
			t = Q30_ONE - ((x2 * t) >> 30) / 6;
			s = (x * t) >> 30;
			m = 127 * s;
			if (quad < 2) begin
				if (m >= Q30_ONE)
					return int'((m - Q30_ONE) >> 30);
				return -int'((Q30_ONE - m) >> 30);
			end
			return -int'((m + Q30_ONE) >> 30);
		endfunction

		function void take_tick(logic rs);
			int unsigned p, h, k;
			int v;
			wave_beat_t b;
			if (rs)
				pos = 16'd0;
			p = span(h);
			if (p == 0) begin
				ticks_silent++;
				return;
			end
			if (pos >= p)
				pos = 16'd0;
			k = pos;
			case (kind)
				WK_SINE: v = sine_at(k, p);
				WK_SAW:  v = ramp_at(k, p);
				WK_TRI:  v = (k < h) ? ramp_at(k, h) : ramp_at(2 * h - k, h);
				default: v = (k < h) ? 127 : -128;
			endcase
			b.sample = v[7:0];
			b.index = k[15:0];
			b.plen = p[16:0];
			b.last = (k + 1 == p);
			due_samples.push_back(b);
			pos = (k + 1 == p) ? 16'd0 : 16'(k + 1);
		endfunction

		function int pending();
			return due_samples.size();
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", what);
		endtask

		task match_sample(logic signed [7:0] smp, logic [15:0] idx, logic [16:0] plen,
				logic lst);
			wave_beat_t b;
			if (due_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected sample %0d at index %0d", smp, idx));
				return;
			end
			b = due_samples.pop_front();
			samples_matched++;
			if (smp !== b.sample)
				report_mismatch($sformatf("index %0d sample %0d, want %0d", b.index, smp,
					b.sample));
			if (idx !== b.index)
				report_mismatch($sformatf("sample_index %0d, want %0d", idx, b.index));
			if (plen !== b.plen)
				report_mismatch($sformatf("index %0d period_length %0d, want %0d", b.index,
					plen, b.plen));
			if (lst !== b.last)
				report_mismatch($sformatf("index %0d last %0b, want %0b", b.index, lst,
					b.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              restart;
	logic              out_valid;
	logic              out_ready;
	logic signed [7:0] sample;
	logic [15:0]       sample_index;
	logic [16:0]       period_length;
	logic              last;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;

	waveform_tracker tracker;
	int unsigned     cycles;
	int              ticks_counted;
	int              settings;
	int              reg_writes;
	bit              long_hold_due;
	bit              long_hold_done;

	periodic_waveform_table_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.restart       (restart),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample        (sample),
		.sample_index  (sample_index),
		.period_length (period_length),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result check first: an output beat always belongs to an earlier input beat
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (out_valid && out_ready)
				tracker.match_sample(sample, sample_index, period_length, last);
			if (in_valid && in_ready)
				tracker.take_tick(restart);
		end
	end

	// receiver: its own stall pattern, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		mode = RX_OPEN;
		mode_left = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_due && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_HALF:   out_ready <= $urandom_range(0, 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= (cycles % 4 == 0);
				endcase
			end
		end
	end

	// wait for every expected sample, then let a dropped tick finish
	task automatic settle();
		do @(posedge clk); while (tracker.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_reg(idx, val);
		reg_writes++;
	endtask

	task automatic configure(logic [1:0] k, logic [3:0] rc, logic [15:0] tn, bit noisy);
		logic [15:0] junk;
		junk = noisy ? 16'($urandom) : 16'd0;
		settle();
		write_reg(CFG_WAVE_KIND, {junk[15:2], k});
		write_reg(CFG_RATE_CODE, {junk[15:4], rc});
		write_reg(CFG_TONE_FREQ, tn);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// bursts of random length with random gaps; pick gives restart bits when not random
	task automatic send_ticks(int n, logic [31:0] pick, bit rand_pick);
		int unsigned half;
		int          burst;
		int          gap;
		int          i;
		bit          live;
		live = (tracker.span(half) != 0);
		burst = $urandom_range(1, 20);
		for (i = 0; i < n; i++) begin
			in_valid <= 1'b1;
			restart <= rand_pick ? ($urandom_range(0, 11) == 0) : pick[i % 32];
			do @(posedge clk); while (!in_ready);
			if (live)
				ticks_counted++;
			burst--;
			if (burst == 0 && i < n - 1) begin
				burst = $urandom_range(1, 20);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		int unsigned half;
		int unsigned rate;
		logic [1:0]  k;
		logic [3:0]  rc;
		logic [15:0] tn;
		int          n;
		int          phase;
		tracker = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		restart <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_WAVE_KIND;
		cfg_data <= 16'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting, then restart mid-period
		send_ticks(3, 32'b100, 1'b0);
		// square, period 4: wraps and both levels
		configure(WK_SQUARE, RC_50066, 16'd12517, 1'b0);
		send_ticks(5, 32'b0, 1'b0);
		// triangle with an odd half period rounded up
		configure(WK_TRI, RC_50066, 16'd5006, 1'b0);
		send_ticks(3, 32'b0, 1'b0);
		// sawtooth, period 2: position left beyond the period wraps
		configure(WK_SAW, RC_6258, 16'd3129, 1'b1);
		send_ticks(3, 32'b0, 1'b0);
		// zero frequency: nothing out, restart still clears
		configure(WK_SAW, RC_6258, 16'd0, 1'b0);
		send_ticks(2, 32'b01, 1'b0);
		// invalid rate code
		configure(WK_TRI, RC_BAD, 16'd1, 1'b1);
		send_ticks(1, 32'b0, 1'b0);
		// full sine period of 8
		configure(WK_SINE, RC_50066, 16'd6258, 1'b0);
		send_ticks(8, 32'b1, 1'b0);
		settle();
		write_reg(REG_SPARE, 16'($urandom));
		cfg_valid <= 1'b0;
		// tone too high for the rate, then the longest period
		configure(WK_SINE, RC_50066, 16'd65535, 1'b0);
		send_ticks(1, 32'b0, 1'b0);
		configure(WK_SINE, RC_50066, 16'd1, 1'b0);
		send_ticks(1, 32'b0, 1'b0);

		phase = 0;
		while (ticks_counted < ITEM_TARGET) begin
			phase++;
			k = 2'($urandom_range(0, 3));
			rc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15)) :
				4'($urandom_range(0, 3));
			rate = tracker.rate_of(rc);
			case ($urandom_range(0, 19))
				0:       tn = 16'd0;
				1:       tn = 16'd1;
				2:       tn = 16'hFFFF;
				3, 4, 5: tn = 16'($urandom_range(1, 65535));
				default: tn = (rate == 0) ? 16'($urandom_range(1, 65535)) :
					16'(rate / $urandom_range(2, 80));
			endcase
			configure(k, rc, tn, $urandom_range(0, 1));
			if (tracker.span(half) == 0)
				n = $urandom_range(1, 4);
			else
				n = $urandom_range(8, 60);
			// long output stall on a setting that really produces samples
			if (!long_hold_due && phase >= 5 && tracker.span(half) != 0) begin
				n = 80;
				long_hold_due = 1'b1;
			end
			send_ticks(n, 32'b0, 1'b1);
		end

		settle();
		if (tracker.pending() != 0)
			tracker.report_mismatch($sformatf("%0d samples never arrived", tracker.pending()));
		$display("covered %0d checked samples over %0d register settings (%0d writes)",
			tracker.samples_matched, settings, reg_writes);
		$display("ticks with no sample: %0d; one long output stall applied", tracker.ticks_silent);
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
